### design/rde_pkg.sv
// Package: shared types, constants and opcodes for the range decoder engine.
`default_nettype none
package rde_pkg;
   localparam int unsigned TOP_VALUE_DEFAULT = 32'd16777216;
   localparam int unsigned LOOKAHEAD_DEFAULT = 8;
   localparam int unsigned INIT_BYTES        = 5;
   localparam int unsigned MAX_DIRECT_BITS   = 32;
   localparam logic [31:0] RANGE_INIT        = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      OP_INIT   = 3'd0,
      OP_BIT    = 3'd1,
      OP_DIRECT = 3'd2,
      OP_THRESH = 3'd3,
      OP_FREQ   = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] first_value;
      logic [31:0] second_value;
      logic [5:0]  bit_count;
      logic [63:0] lookahead_bytes;
   } req_type;

   typedef struct packed {
      logic [31:0] decoded_value;
      logic [3:0]  bytes_used;
      logic [31:0] range_now;
      logic [31:0] code_now;
      logic        divide_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_BIT_MUL,
      ST_BIT_CMP,
      ST_DIRECT,
      ST_DIV1,
      ST_DIV2,
      ST_THRESH_FIN,
      ST_FREQ_MUL,
      ST_FREQ_APPLY,
      ST_RENORM,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_INIT_BYTE,
      CMD_BIT_MUL,
      CMD_BIT_CMP,
      CMD_DIRECT_STEP,
      CMD_DIV1_START,
      CMD_DIV2_START,
      CMD_DIV_STEP,
      CMD_DIV_ERROR,
      CMD_THRESH_FIN,
      CMD_FREQ_MUL,
      CMD_FREQ_APPLY,
      CMD_RENORM_STEP
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
   } cmd_type;

   typedef struct packed {
      op_type     op;
      logic       count_done;
      logic       div_done;
      logic       div_zero;
      logic       renorm_done;
   } status_type;
endpackage
`default_nettype wire

### design/rde_ctrl.sv
// Controller: command sequencing state machine for the range decoder engine.
`default_nettype none
module rde_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire rde_pkg::status_type status,
   output rde_pkg::cmd_type        cmd
);
   import rde_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.code  = CMD_NONE;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.code = CMD_LOAD;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            case (status.op)
               OP_INIT: begin
                  cmd.code = CMD_INIT_BYTE;
                  if (status.count_done) state_in = ST_DONE;
               end
               OP_BIT:    state_in = ST_BIT_MUL;
               OP_DIRECT: state_in = ST_DIRECT;
               OP_THRESH: begin
                  cmd.code = CMD_DIV1_START;
                  state_in = ST_DIV1;
               end
               OP_FREQ:   state_in = ST_FREQ_MUL;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_BIT_MUL: begin
            cmd.code = CMD_BIT_MUL;
            state_in = ST_BIT_CMP;
         end
         ST_BIT_CMP: begin
            cmd.code = CMD_BIT_CMP;
            state_in = ST_RENORM;
         end
         ST_DIRECT: begin
            if (status.count_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.code = CMD_DIRECT_STEP;
            end
         end
         ST_DIV1: begin
            if (status.div_zero) begin
               cmd.code = CMD_DIV_ERROR;
               state_in = ST_DONE;
            end else if (status.div_done) begin
               cmd.code = CMD_DIV2_START;
               state_in = ST_DIV2;
            end else begin
               cmd.code = CMD_DIV_STEP;
            end
         end
         ST_DIV2: begin
            if (status.div_done) begin
               state_in = ST_THRESH_FIN;
            end else begin
               cmd.code = CMD_DIV_STEP;
            end
         end
         ST_THRESH_FIN: begin
            cmd.code = CMD_THRESH_FIN;
            state_in = ST_DONE;
         end
         ST_FREQ_MUL: begin
            cmd.code = CMD_FREQ_MUL;
            state_in = ST_FREQ_APPLY;
         end
         ST_FREQ_APPLY: begin
            cmd.code = CMD_FREQ_APPLY;
            state_in = ST_RENORM;
         end
         ST_RENORM: begin
            if (status.renorm_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.code = CMD_RENORM_STEP;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

### design/rde_datapath.sv
// Datapath: range/code state, byte window, multiplier and restoring divider.
`default_nettype none
module rde_datapath #(
   parameter logic [31:0] TOP_VALUE = rde_pkg::TOP_VALUE_DEFAULT,
   parameter int unsigned LOOKAHEAD = rde_pkg::LOOKAHEAD_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rde_pkg::req_type    req_data,
   input  wire rde_pkg::cmd_type    cmd,
   output rde_pkg::status_type      status,
   output rde_pkg::rsp_type         rsp_data
);
   import rde_pkg::*;

   localparam int unsigned UW = $clog2(LOOKAHEAD + 1);

   logic [31:0] range_ff, range_in;
   logic [31:0] code_ff, code_in;
   logic [2:0]  op_ff, op_in;
   logic [31:0] v1_ff, v1_in;
   logic [31:0] v2_ff, v2_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] win_ff, win_in;
   logic [UW-1:0] used_ff, used_in;
   logic [31:0] result_ff, result_in;
   logic        err_ff, err_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] div_num_ff, div_num_in;
   logic [31:0] div_den_ff, div_den_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;

   logic        have_byte;
   logic [7:0]  next_byte;
   logic [31:0] bound_shift;
   logic [31:0] rng_half;
   logic [31:0] cod_diff;
   logic [32:0] rem_sh;
   logic [33:0] rem_sub;

   assign have_byte = (32'(used_ff) < LOOKAHEAD);
   assign next_byte = (used_ff < UW'(8)) ? win_ff[63:56] : 8'd0;
   assign bound_shift = (cnt_ff < 6'd32) ? (range_ff >> cnt_ff[4:0]) : 32'd0;
   assign rng_half = range_ff >> 1;
   assign cod_diff = code_ff - rng_half;
   assign rem_sh = {rem_ff[31:0], div_num_ff[31]};
   assign rem_sub = {1'b0, rem_sh} - {2'b00, div_den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= '0;
         code_ff  <= '0;
      end else begin
         range_ff <= range_in;
         code_ff  <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      v1_ff      <= v1_in;
      v2_ff      <= v2_in;
      cnt_ff     <= cnt_in;
      win_ff     <= win_in;
      used_ff    <= used_in;
      result_ff  <= result_in;
      err_ff     <= err_in;
      prod_ff    <= prod_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
      div_cnt_ff <= div_cnt_in;
   end

   always_comb begin
      range_in   = range_ff;
      code_in    = code_ff;
      op_in      = op_ff;
      v1_in      = v1_ff;
      v2_in      = v2_ff;
      cnt_in     = cnt_ff;
      win_in     = win_ff;
      used_in    = used_ff;
      result_in  = result_ff;
      err_in     = err_ff;
      prod_in    = prod_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      div_num_in = div_num_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      case (cmd.code)
         CMD_LOAD: begin
            op_in     = req_data.op;
            v1_in     = req_data.first_value;
            v2_in     = req_data.second_value;
            win_in    = req_data.lookahead_bytes;
            used_in   = '0;
            result_in = '0;
            err_in    = 1'b0;
            if (req_data.op == OP_INIT) begin
               cnt_in   = 6'(INIT_BYTES);
               code_in  = '0;
               range_in = RANGE_INIT;
            end else if (req_data.op == OP_DIRECT && req_data.bit_count > 6'(MAX_DIRECT_BITS)) begin
               cnt_in = 6'(MAX_DIRECT_BITS);
            end else begin
               cnt_in = req_data.bit_count;
            end
         end
         CMD_INIT_BYTE: begin
            if (cnt_ff != 6'd0) begin
               cnt_in = cnt_ff - 6'd1;
               if (have_byte) begin
                  code_in = {code_ff[23:0], next_byte};
                  win_in  = win_ff << 8;
                  used_in = used_ff + UW'(1);
               end
            end
         end
         CMD_BIT_MUL: prod_in = bound_shift * v1_ff;
         CMD_BIT_CMP: begin
            if (code_ff < prod_ff) begin
               range_in = prod_ff;
            end else begin
               code_in   = code_ff - prod_ff;
               range_in  = range_ff - prod_ff;
               result_in = 32'd1;
            end
         end
         CMD_DIRECT_STEP: begin
            cnt_in    = cnt_ff - 6'd1;
            result_in = {result_ff[30:0], ~cod_diff[31]};
            range_in  = rng_half;
            code_in   = cod_diff[31] ? code_ff : cod_diff;
            if (rng_half < TOP_VALUE && have_byte) begin
               range_in = rng_half << 8;
               code_in  = {(cod_diff[31] ? code_ff[23:0] : cod_diff[23:0]), next_byte};
               win_in   = win_ff << 8;
               used_in  = used_ff + UW'(1);
            end
         end
         CMD_DIV1_START, CMD_DIV2_START: begin
            div_num_in = (cmd.code == CMD_DIV1_START) ? range_ff : code_ff;
            div_den_in = (cmd.code == CMD_DIV1_START) ? v1_ff : quo_ff;
            rem_in     = '0;
            quo_in     = '0;
            div_cnt_in = 6'd32;
         end
         CMD_DIV_STEP: begin
            div_cnt_in = div_cnt_ff - 6'd1;
            div_num_in = div_num_ff << 1;
            if (!rem_sub[33]) begin
               rem_in = rem_sub[32:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[30:0], 1'b0};
            end
         end
         CMD_DIV_ERROR: err_in = 1'b1;
         CMD_THRESH_FIN: begin
            range_in  = div_den_ff;
            result_in = quo_ff;
         end
         CMD_FREQ_MUL: prod_in = v1_ff * range_ff;
         CMD_FREQ_APPLY: begin
            code_in  = code_ff - prod_ff;
            range_in = range_ff * v2_ff;
         end
         CMD_RENORM_STEP: begin
            code_in = {code_ff[23:0], next_byte};
            range_in = range_ff << 8;
            win_in  = win_ff << 8;
            used_in = used_ff + UW'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      status.op          = op_type'(op_ff);
      status.count_done  = (cnt_ff == 6'd0);
      status.div_done    = (div_cnt_ff == 6'd0);
      status.div_zero    = (div_cnt_ff == 6'd0) && (v1_ff == 32'd0 || quo_ff == 32'd0);
      status.renorm_done = !(range_ff < TOP_VALUE && have_byte);
   end

   always_comb begin
      rsp_data.decoded_value = result_ff;
      rsp_data.bytes_used    = (32'(used_ff) > 32'd15) ? 4'd15 : 4'(used_ff);
      rsp_data.range_now     = range_ff;
      rsp_data.code_now      = code_ff;
      rsp_data.divide_error  = err_ff;
   end
endmodule
`default_nettype wire

### design/range_decoder_engine_top.sv
// Top level: range decoder engine, controller plus datapath.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_data (rde_pkg::req_type)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_data (rde_pkg::rsp_type)
//
// One command at a time. Init takes up to INIT_BYTES bytes; decode bit multiplies,
// compares, renormalizes; direct bits take one step per bit; threshold runs two
// 32-step restoring divisions (ending after the first on a zero divisor); frequency
// decode multiplies, applies, renormalizes. After each rsp transfer the controller
// returns to idle, where the next req is taken. Reset clears range, code and the
// controller. The result holds in the output stage until the rsp transfer completes.
`default_nettype none
module range_decoder_engine_top #(
   parameter logic [31:0] TOP_VALUE = rde_pkg::TOP_VALUE_DEFAULT,
   parameter int unsigned LOOKAHEAD = rde_pkg::LOOKAHEAD_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rde_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rde_pkg::rsp_type      rsp_data
);
   import rde_pkg::*;

   cmd_type    cmd;
   status_type status;

   rde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rde_datapath #(
      .TOP_VALUE (TOP_VALUE),
      .LOOKAHEAD (LOOKAHEAD)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );
endmodule
`default_nettype wire
